// File: src/order_finding_factorizer_core_defines.svh
// assertion macros for the order finding factorizer
`ifndef ORDER_FINDING_FACTORIZER_CORE_DEFINES_SVH
`define ORDER_FINDING_FACTORIZER_CORE_DEFINES_SVH
// implication checked on every edge outside reset
`define OFF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define OFF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: src/off_pkg.sv
// shared types and constants for the order finding factorizer
package off_pkg;
    localparam int W = 16;
    typedef logic [W-1:0] t_word;
    typedef logic [2*W-1:0] t_dword;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,        // load slot; n is latched on i_load, not by this op
        OP_CYC_INIT,    // start cyclic check: m = n (halved if odd*2)
        OP_CYC_DSTEP,   // step trial divisor d
        OP_CYC_DIVP,    // divide m by p
        OP_BASE_INIT,   // a = 2
        OP_BASE_NEXT,   // a++
        OP_GCD_AN,      // gcd(a, n) start
        OP_ORD_INIT,    // p = a, r = 1
        OP_ORD_STEP,    // r++, p = p*a mod n
        OP_HALF_INIT,   // h = 1, e = 0
        OP_HALF_STEP,   // h = h*a mod n, e++
        OP_GCD_X,       // gcd(h-1, n)
        OP_GCD_Y,       // gcd(h+1, n)
        OP_MUL_START    // d = m: take m as p when no divisor found
    } t_op;

    typedef struct packed {
        t_op  op;
        logic mod_start; // start remainder unit
        logic gcd_start;
        logic gcd_sel_y;
        logic gcd_sel_base;
    } t_cmd;

    typedef struct packed {
        logic mod_busy;
        logic gcd_busy;
        logic n_lt2;
        logic n_mod4_0;
        logic n_eq4;
        logic m_eq1;
        logic d_sq_gt_m;
        logic m_mod_d0;   // rem result zero
        logic a_lt_n;
        logic gcd_one;
        logic p_eq1;
        logic r_lt_n;
        logic r_odd;
        logic e_eq_half;
        logic y_zero;
    } t_sts;
endpackage

// File: src/off_remu.sv
// restoring divider computing x mod y, one quotient bit a cycle
module off_remu import off_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_dword i_x,
    input  t_word  i_y,
    output logic   o_busy,
    output t_word  o_rem,
    output t_dword o_quo
);
    localparam int CW = $clog2(2*W+1);
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [W:0]    r_rem;
    t_dword        r_x;
    t_word         r_y;
    logic [W+1:0]  w_sh;
    logic [W+1:0]  w_sub;

    assign w_sh  = {r_rem, r_x[2*W-1]};
    assign w_sub = w_sh - {2'b00, r_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(2*W);
            r_x    <= i_x;
            r_y    <= i_y;
            r_rem  <= '0;
        end else if (r_busy) begin
            if (w_sub[W+1]) begin
                r_rem <= w_sh[W:0];
                r_x   <= {r_x[2*W-2:0], 1'b0};
            end else begin
                r_rem <= w_sub[W:0];
                r_x   <= {r_x[2*W-2:0], 1'b1};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem[W-1:0];
    assign o_quo  = r_x;
endmodule

// File: src/off_dp.sv
// datapath: number registers, remainder unit, gcd sequencing
module off_dp import off_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_load,
    input  t_word i_number,
    input  t_cmd  i_cmd,
    output t_sts  o_sts,
    output t_word o_factor_p,
    output t_word o_factor_q,
    output t_word o_base,
    output t_word o_order
);
    t_word  r_n, r_m, r_d, r_a, r_p, r_r, r_h, r_e, r_gx, r_gy;
    logic   r_gbusy;
    logic   r_gwait;
    logic   r_gsel_y;
    t_word  r_fp, r_fq;
    logic   r_rwait;
    t_op    r_rop;
    logic   w_rbusy;
    logic   w_rstart;
    t_dword w_rx;
    t_word  w_ry;
    t_word  w_rem;
    t_dword w_quo;
    t_word  w_hp1;
    t_word  w_hm1;
    logic [2*W+1:0] w_dsq;

    // remainder operand select
    always_comb begin
        w_rstart = 1'b0;
        w_rx     = '0;
        w_ry     = r_n;
        if (r_gbusy && !r_gwait && r_gy != '0) begin
            w_rstart = 1'b1;
            w_rx     = {{W{1'b0}}, r_gx};
            w_ry     = r_gy;
        end else if (i_cmd.mod_start) begin
            w_rstart = 1'b1;
            unique case (i_cmd.op)
                OP_CYC_DSTEP, OP_CYC_DIVP: begin
                    w_rx = {{W{1'b0}}, r_m};
                    w_ry = r_d;
                end
                OP_ORD_STEP:  w_rx = t_dword'(r_p) * t_dword'(r_a);
                OP_HALF_STEP: w_rx = t_dword'(r_h) * t_dword'(r_a);
                default:      w_rx = {{W{1'b0}}, r_a};
            endcase
        end
    end

    off_remu u_remu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_rstart),
        .i_x     (w_rx),
        .i_y     (w_ry),
        .o_busy  (w_rbusy),
        .o_rem   (w_rem),
        .o_quo   (w_quo)
    );

    assign w_hp1 = (r_h == r_n - 1'b1) ? '0 : r_h + 1'b1;
    assign w_hm1 = (r_h == '0) ? r_n - 1'b1 : r_h - 1'b1;
    assign w_dsq = (2*W+2)'(r_d) * (2*W+2)'(r_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gbusy <= 1'b0;
            r_gwait <= 1'b0;
            r_rwait <= 1'b0;
            r_rop   <= OP_NONE;
        end else begin
            // gcd engine: one remainder per round
            if (i_cmd.gcd_start) begin
                r_gbusy  <= 1'b1;
                r_gwait  <= 1'b0;
                r_gsel_y <= i_cmd.gcd_sel_y;
                r_gy     <= r_n;
                if (i_cmd.gcd_sel_base) begin
                    r_gx <= r_a;
                end else if (i_cmd.gcd_sel_y) begin
                    r_gx <= w_hp1;
                end else begin
                    r_gx <= w_hm1;
                end
            end else if (r_gbusy) begin
                if (!r_gwait) begin
                    if (r_gy == '0) begin
                        r_gbusy <= 1'b0;
                        if (r_gsel_y) begin
                            r_fq <= r_gx;
                        end else begin
                            r_fp <= r_gx;
                        end
                    end else begin
                        r_gwait <= 1'b1;
                    end
                end else if (!w_rbusy) begin
                    r_gwait <= 1'b0;
                    r_gx    <= r_gy;
                    r_gy    <= w_rem;
                end
            end
            if (i_cmd.mod_start) begin
                r_rwait <= 1'b1;
                r_rop   <= i_cmd.op;
            end else if (r_rwait && !w_rbusy) begin
                r_rwait <= 1'b0;
                unique case (r_rop)
                    OP_ORD_STEP:  r_p <= w_rem;
                    OP_HALF_STEP: r_h <= w_rem;
                    OP_CYC_DIVP:  if (w_rem == '0) r_m <= w_quo[W-1:0];
                    default: ;
                endcase
            end
            // n is taken on the accepting edge
            if (i_load) begin
                r_n <= i_number;
            end
            unique case (i_cmd.op)
                OP_CYC_INIT: begin
                    r_m <= r_n[0] ? r_n : {1'b0, r_n[W-1:1]};
                    r_d <= t_word'(3);
                end
                OP_CYC_DSTEP: r_d <= r_d + t_word'(2);
                OP_CYC_DIVP:  ;
                OP_BASE_INIT: r_a <= t_word'(2);
                OP_BASE_NEXT: r_a <= r_a + 1'b1;
                OP_ORD_INIT: begin
                    r_p <= r_a;
                    r_r <= t_word'(1);
                end
                OP_ORD_STEP:  r_r <= r_r + 1'b1;
                OP_HALF_INIT: begin
                    r_h <= t_word'(1);
                    r_e <= '0;
                end
                OP_HALF_STEP: r_e <= r_e + 1'b1;
                OP_MUL_START: r_d <= r_m; // p = m when no divisor found
                default: ;
            endcase
        end
    end

    always_comb begin
        o_sts.mod_busy  = r_rwait;
        o_sts.gcd_busy  = r_gbusy;
        o_sts.n_lt2     = r_n < t_word'(2);
        o_sts.n_mod4_0  = r_n[1:0] == 2'b00;
        o_sts.n_eq4     = r_n == t_word'(4);
        o_sts.m_eq1     = r_m == t_word'(1);
        o_sts.d_sq_gt_m = w_dsq > (2*W+2)'(r_m);
        o_sts.m_mod_d0  = w_rem == '0;
        o_sts.a_lt_n    = r_a < r_n;
        o_sts.gcd_one   = r_fp == t_word'(1);
        o_sts.p_eq1     = r_p == t_word'(1);
        o_sts.r_lt_n    = r_r < r_n;
        o_sts.r_odd     = r_r[0];
        o_sts.e_eq_half = r_e == {1'b0, r_r[W-1:1]};
        o_sts.y_zero    = w_hp1 == '0;
    end

    assign o_factor_p = r_fp;
    assign o_factor_q = r_fq;
    assign o_base     = r_a;
    assign o_order    = r_r;
endmodule

// File: src/off_ctrl.sv
// controller: sequences the base search and drives the handshake
module off_ctrl import off_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_load,
    output logic o_valid,
    input  logic i_stall,
    output logic o_found,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_CHK, S_CYC_INIT, S_CYC_D, S_CYC_DW, S_CYC_P, S_CYC_PW,
        S_CYC_END, S_BASE, S_DIVW, S_GCDW, S_ORD, S_ORDW, S_HALF, S_HALFW,
        S_GX, S_GXW, S_GY, S_GYW, S_OUT
    } t_state;

    t_state r_state;
    logic   r_valid;
    logic   r_found;
    logic   w_cmd_idle;

    // a command issued on the last edge lands in the datapath on this one,
    // so status is only read once no command is in flight
    assign w_cmd_idle = (o_cmd == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_found <= 1'b0;
            o_cmd   <= '0;
        end else begin
            o_cmd <= '0;
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_found <= 1'b0;
                    if (i_sts.n_lt2 || i_sts.n_eq4) begin
                        r_state <= S_OUT;
                        r_valid <= 1'b1;
                    end else if (i_sts.n_mod4_0) begin
                        o_cmd.op <= OP_BASE_INIT;
                        r_state  <= S_BASE;
                    end else begin
                        o_cmd.op <= OP_CYC_INIT;
                        r_state  <= S_CYC_INIT;
                    end
                end
                // find smallest odd divisor p of m, then strip p
                S_CYC_INIT: if (w_cmd_idle) begin
                    if (i_sts.m_eq1) begin
                        r_state <= S_OUT;
                        r_valid <= 1'b1;
                    end else begin
                        r_state <= S_CYC_D;
                    end
                end
                S_CYC_D: if (w_cmd_idle) begin
                    if (i_sts.d_sq_gt_m) begin
                        o_cmd.op <= OP_MUL_START;
                        r_state  <= S_CYC_P;
                    end else begin
                        o_cmd.op        <= OP_CYC_DIVP;
                        o_cmd.mod_start <= 1'b1;
                        r_state         <= S_CYC_DW;
                    end
                end
                S_CYC_DW: if (!i_sts.mod_busy && !o_cmd.mod_start) begin
                    if (i_sts.m_mod_d0) begin
                        r_state <= S_CYC_P;
                    end else begin
                        o_cmd.op <= OP_CYC_DSTEP;
                        r_state  <= S_CYC_D;
                    end
                end
                S_CYC_P: begin
                    o_cmd.op        <= OP_CYC_DIVP;
                    o_cmd.mod_start <= 1'b1;
                    r_state         <= S_CYC_PW;
                end
                S_CYC_PW: if (!i_sts.mod_busy && !o_cmd.mod_start) begin
                    r_state <= i_sts.m_mod_d0 ? S_CYC_P : S_CYC_END;
                end
                S_CYC_END: begin
                    if (i_sts.m_eq1) begin
                        r_state <= S_OUT;
                        r_valid <= 1'b1;
                    end else begin
                        o_cmd.op <= OP_BASE_INIT;
                        r_state  <= S_BASE;
                    end
                end
                S_BASE: if (w_cmd_idle) begin
                    if (!i_sts.a_lt_n) begin
                        r_state <= S_OUT;
                        r_valid <= 1'b1;
                    end else begin
                        o_cmd.gcd_start    <= 1'b1;
                        o_cmd.gcd_sel_base <= 1'b1;
                        r_state            <= S_GCDW;
                    end
                end
                S_GCDW: if (!i_sts.gcd_busy && !o_cmd.gcd_start) begin
                    if (i_sts.gcd_one) begin
                        o_cmd.op <= OP_ORD_INIT;
                        r_state  <= S_ORD;
                    end else begin
                        o_cmd.op <= OP_BASE_NEXT;
                        r_state  <= S_BASE;
                    end
                end
                S_ORD: if (w_cmd_idle) begin
                    if (i_sts.p_eq1 || !i_sts.r_lt_n) begin
                        if (!i_sts.p_eq1 || i_sts.r_odd) begin
                            o_cmd.op <= OP_BASE_NEXT;
                            r_state  <= S_BASE;
                        end else begin
                            o_cmd.op <= OP_HALF_INIT;
                            r_state  <= S_HALF;
                        end
                    end else begin
                        o_cmd.op        <= OP_ORD_STEP;
                        o_cmd.mod_start <= 1'b1;
                        r_state         <= S_ORDW;
                    end
                end
                S_ORDW: if (!i_sts.mod_busy && !o_cmd.mod_start) begin
                    r_state <= S_ORD;
                end
                S_HALF: if (w_cmd_idle) begin
                    if (i_sts.e_eq_half) begin
                        if (i_sts.y_zero) begin
                            o_cmd.op <= OP_BASE_NEXT;
                            r_state  <= S_BASE;
                        end else begin
                            r_state <= S_GX;
                        end
                    end else begin
                        o_cmd.op        <= OP_HALF_STEP;
                        o_cmd.mod_start <= 1'b1;
                        r_state         <= S_HALFW;
                    end
                end
                S_HALFW: if (!i_sts.mod_busy && !o_cmd.mod_start) begin
                    r_state <= S_HALF;
                end
                S_GX: begin
                    o_cmd.gcd_start <= 1'b1;
                    r_state         <= S_GXW;
                end
                S_GXW: if (!i_sts.gcd_busy && !o_cmd.gcd_start) begin
                    r_state <= S_GY;
                end
                S_GY: begin
                    o_cmd.gcd_start <= 1'b1;
                    o_cmd.gcd_sel_y <= 1'b1;
                    r_state         <= S_GYW;
                end
                S_GYW: if (!i_sts.gcd_busy && !o_cmd.gcd_start) begin
                    r_found <= 1'b1;
                    r_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: if (!i_stall) begin
                    r_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_load  = (r_state == S_IDLE) && i_valid;
    assign o_valid = r_valid;
    assign o_found = r_found;
endmodule

// File: src/order_finding_factorizer_core.sv
// top level of the order finding factorizer
//  channel | valid          | stall          | payload
//  in      | i_valid        | o_stall        | i_number
//  out     | o_valid        | i_stall        | o_found o_factor_p o_factor_q o_base o_order
// one word at a time; run time depends on n: each order or power step is one
// remainder unit pass, gcds take one pass per Euclid round, and the serial
// remainder unit sets the worst case.
// reset is synchronous active low and clears control state only.
// the result word holds while i_stall is high; input stalls until it is taken.
module order_finding_factorizer_core import off_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_word i_number,
    output logic  o_valid,
    input  logic  i_stall,
    output logic  o_found,
    output t_word o_factor_p,
    output t_word o_factor_q,
    output t_word o_base,
    output t_word o_order
);
    t_cmd  w_cmd;
    t_sts  w_sts;
    logic  w_load;
    logic  w_found;
    t_word w_fp, w_fq, w_b, w_r;

    off_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_load  (w_load),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_found (w_found),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    off_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_number   (i_number),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_factor_p (w_fp),
        .o_factor_q (w_fq),
        .o_base     (w_b),
        .o_order    (w_r)
    );

    assign o_found    = w_found;
    assign o_factor_p = w_found ? w_fp : '0;
    assign o_factor_q = w_found ? w_fq : '0;
    assign o_base     = w_found ? w_b : '0;
    assign o_order    = w_found ? w_r : '0;
endmodule

// File: src/off_checker.sv
// port checker for the order finding factorizer
`include "order_finding_factorizer_core_defines.svh"
module off_checker import off_pkg::*; (
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_valid,
    input logic  o_stall,
    input logic  o_valid,
    input logic  i_stall,
    input logic  o_found,
    input t_word o_base,
    input t_word o_order
);
    `OFF_ASSERT_IMPL(a_busy_out, i_clk, i_rst_n, o_valid, o_stall)
    `OFF_ASSERT_IMPL(a_nf_zero, i_clk, i_rst_n, o_valid && !o_found, o_base == '0)
    `OFF_ASSERT_IMPL(a_even, i_clk, i_rst_n, o_valid && o_found, !o_order[0])
    `OFF_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_base))
endmodule

bind order_finding_factorizer_core off_checker u_chk (.*);
